// File: rtl/core/hafs_pkg.sv
`default_nettype none

package hafs_pkg;

  localparam logic [31:0] START_CODE    = 32'h0000_0001;
  localparam logic [31:0] HISTORY_RESET = 32'hFFFF_FFFF;
  localparam int unsigned NAL_TYPE_BITS = 5;
  localparam int unsigned START_CODE_BYTES = 4;

  typedef enum logic [NAL_TYPE_BITS-1:0] {
    NAL_SLICE = 5'h01,
    NAL_SPS   = 5'h07
  } nal_type_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [31:0] frame_offset;
    logic [31:0] frame_length;
    logic        key_frame;
  } out_t;

endpackage

`default_nettype wire

// File: rtl/core/hafs_framer.sv
`default_nettype none

module hafs_framer #(
  parameter int unsigned POSITION_BITS = 32
) (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             accept_i,
  input  hafs_pkg::in_t   item_i,
  output logic            res_valid_o,
  output hafs_pkg::out_t  res_o
);
  import hafs_pkg::*;

  logic [31:0]              hist_q, hist_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic                     open_q, open_d;
  logic [POSITION_BITS-1:0] ostart_q, ostart_d;
  logic                     okey_q, okey_d;

  logic [NAL_TYPE_BITS-1:0] nal_type;
  logic                     hit;
  logic [POSITION_BITS-1:0] sc_pos;
  logic [POSITION_BITS-1:0] len;
  logic [POSITION_BITS+31:0] start_ext;
  logic [POSITION_BITS+31:0] len_ext;

  assign nal_type = item_i.data_byte[NAL_TYPE_BITS-1:0];
  assign hit      = (hist_q == START_CODE) &&
                    ((nal_type == NAL_SPS) || (nal_type == NAL_SLICE));
  // start code sits four bytes before the header byte
  assign sc_pos   = pos_q - POSITION_BITS'(START_CODE_BYTES);
  assign len      = sc_pos - ostart_q;

  // zero-extend or truncate positions to the 32-bit result fields
  assign start_ext = {32'b0, ostart_q};
  assign len_ext   = {32'b0, len};

  assign res_valid_o         = accept_i && hit && open_q;
  assign res_o.frame_offset  = start_ext[31:0];
  assign res_o.frame_length  = len_ext[31:0];
  assign res_o.key_frame     = okey_q;

  always_comb begin
    hist_d   = hist_q;
    pos_d    = pos_q;
    open_d   = open_q;
    ostart_d = ostart_q;
    okey_d   = okey_q;
    if (accept_i) begin
      if (item_i.last_byte) begin
        // drop the open frame and restart the stream
        hist_d   = HISTORY_RESET;
        pos_d    = '0;
        open_d   = 1'b0;
        ostart_d = '0;
        okey_d   = 1'b0;
      end else begin
        hist_d = {hist_q[23:0], item_i.data_byte};
        pos_d  = pos_q + POSITION_BITS'(1);
        if (hit) begin
          open_d   = 1'b1;
          ostart_d = sc_pos;
          okey_d   = (nal_type == NAL_SPS);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q   <= HISTORY_RESET;
      pos_q    <= '0;
      open_q   <= 1'b0;
      ostart_q <= '0;
      okey_q   <= 1'b0;
    end else begin
      hist_q   <= hist_d;
      pos_q    <= pos_d;
      open_q   <= open_d;
      ostart_q <= ostart_d;
      okey_q   <= okey_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/hafs_out_buf.sv
`default_nettype none

module hafs_out_buf (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             res_valid_i,
  input  hafs_pkg::out_t  res_i,
  output logic            full_o,
  output logic            out_valid_o,
  input  wire             out_stall_i,
  output hafs_pkg::out_t  out_data_o
);
  import hafs_pkg::*;

  logic out_valid_q, out_valid_d;
  out_t out_q, out_d;
  logic skid_valid_q, skid_valid_d;
  out_t skid_q, skid_d;
  logic free;

  // output register can take a new request this cycle
  assign free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (free) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = res_valid_i;
        out_d       = res_i;
      end
    end else if (res_valid_i) begin
      // hold the new request behind the stalled one
      skid_valid_d = 1'b1;
      skid_d       = res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// File: rtl/core/h264_annexb_frame_splitter_top.sv
// H.264 Annex B frame splitter.
// Input channel: one stream byte per request (data_byte, last_byte) on
// in_valid_i / in_stall_o. Output channel: one closed frame per request
// (frame_offset, frame_length, key_frame) on out_valid_o / out_stall_i.
// A frame opens at a 00 00 00 01 start code whose NAL header type is SPS
// or non-IDR slice, and is reported when the next such start code arrives.
// Throughput: one byte per cycle while in_stall_o is low; the scan of the
// four-byte history against the header byte is combinational.
// Output: the result for the header byte that closes the frame is registered
// in the output register, or in the skid entry while that register is stalled.
// A two-entry output buffer lets bytes keep flowing while a result waits;
// in_stall_o rises only when both entries are held by a stalled receiver.
// A byte with last_byte set is scanned first, then the open frame is
// dropped and position and history return to their reset state.
// Reset: asynchronous, active low; clears the history to all ones, the
// byte position to zero and empties the output buffer.
`default_nettype none

module h264_annexb_frame_splitter_top #(
  parameter int unsigned POSITION_BITS = 32
) (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             in_valid_i,
  output logic            in_stall_o,
  input  hafs_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  wire             out_stall_i,
  output hafs_pkg::out_t  out_data_o
);
  import hafs_pkg::*;

  logic accept;
  logic res_valid;
  out_t res;
  logic buf_full;

  assign in_stall_o = buf_full;
  assign accept     = in_valid_i && !buf_full;

  hafs_framer #(
    .POSITION_BITS(POSITION_BITS)
  ) u_framer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .item_i     (in_data_i),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  hafs_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_valid_i(res_valid),
    .res_i      (res),
    .full_o     (buf_full),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

// File: rtl/core/hafs_checker.sv
`default_nettype none

module hafs_checker (
  input wire            clk_i,
  input wire            rst_ni,
  input wire            in_valid_i,
  input wire            in_stall_o,
  input hafs_pkg::in_t  in_data_i,
  input wire            out_valid_o,
  input wire            out_stall_i,
  input hafs_pkg::out_t out_data_o
);
  import hafs_pkg::*;

  // a full buffer always presents a result
  a_stall_has_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  // the buffer fills only behind a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stall without a stalled result");

  // no result without an accepted byte
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o && !(in_valid_i && !in_stall_o)) |=> !out_valid_o)
    else $error("result appeared without input");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed");

endmodule

bind h264_annexb_frame_splitter_top hafs_checker u_hafs_checker (.*);

`default_nettype wire
